>>> design/envpf_pkg.sv
// ----------------------------------------------------------------------------
// envpf_pkg
// Types, constants and the CRC-8 step shared by the framer modules.
// ----------------------------------------------------------------------------
package envpf_pkg;

  localparam int FRAME_LEN = 18;
  localparam int HDR_LEN   = FRAME_LEN - 1;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  localparam logic [IDX_W-1:0] CRC_IDX = IDX_W'(FRAME_LEN - 1);

  localparam logic [7:0] FRAME_MAGIC   = 8'hA5;
  localparam logic [7:0] FRAME_VERSION = 8'h01;
  localparam logic [7:0] CRC_POLY      = 8'h07;
  localparam logic [7:0] CRC_INIT      = 8'h00;

  localparam logic [13:0]        HUM_MAX   = 14'd10000;
  localparam logic signed [31:0] LAT_LIMIT = 32'sd900000000;
  localparam logic signed [31:0] LON_LIMIT = 32'sd1800000000;

  // One classified measurement, ready for serialization
  typedef struct packed {
    logic [7:0]  src;
    logic [31:0] lon;
    logic [31:0] lat;
    logic [15:0] hum;
    logic [15:0] temp;
    logic [15:0] seq;
  } rec_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/envpf_front.sv
// ----------------------------------------------------------------------------
// envpf_front
// Accepts measurement words, saturates fields, tags them with sequence
// number and source id, and pushes the record into the queue.
// ----------------------------------------------------------------------------
module envpf_front import envpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_data,
  input  logic        push_ready,
  output logic        push_valid,
  output rec_t        push_data
);

  logic [15:0]        seq_r, seq_nxt;
  logic [7:0]         src_r, src_nxt;
  logic [15:0]        temp;
  logic [13:0]        hum;
  logic signed [31:0] lat;
  logic signed [31:0] lon;

  assign temp = in_tdata[15:0];
  assign hum  = in_tdata[29:16];
  assign lat  = 32'($signed(in_tdata[60:30]));
  assign lon  = $signed(in_tdata[92:61]);

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  always_comb begin
    push_data.seq  = seq_r;
    push_data.temp = temp;
    push_data.hum  = {2'b00, (hum > HUM_MAX) ? HUM_MAX : hum};
    priority if (lat > LAT_LIMIT) begin
      push_data.lat = LAT_LIMIT;
    end else if (lat < -LAT_LIMIT) begin
      push_data.lat = -LAT_LIMIT;
    end else begin
      push_data.lat = lat;
    end
    priority if (lon > LON_LIMIT) begin
      push_data.lon = LON_LIMIT;
    end else if (lon < -LON_LIMIT) begin
      push_data.lon = -LON_LIMIT;
    end else begin
      push_data.lon = lon;
    end
    push_data.src = src_r;
  end

  always_comb begin
    seq_nxt = (in_tvalid && push_ready) ? seq_r + 16'd1 : seq_r;
    src_nxt = cfg_valid ? cfg_data : src_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
      src_r <= '0;
    end else begin
      seq_r <= seq_nxt;
      src_r <= src_nxt;
    end
  end

endmodule

>>> design/envpf_queue.sv
// ----------------------------------------------------------------------------
// envpf_queue
// Small record queue between the front end and the serializer.
// ----------------------------------------------------------------------------
module envpf_queue import envpf_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  rec_t push_data,
  output logic pop_valid,
  input  logic pop,
  output rec_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t            mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> design/envpf_serializer.sv
// ----------------------------------------------------------------------------
// envpf_serializer
// Walks the queue head byte by byte, runs the CRC-8 along the way and
// drives the registered output stream; pops the record on the CRC byte.
// ----------------------------------------------------------------------------
module envpf_serializer import envpf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rec_valid,
  input  rec_t       rec,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic [HDR_LEN*8-1:0] hdr;
  logic [HDR_LEN*8-1:0] hdr_sh;
  logic [7:0]           cur_byte;
  logic                 adv, at_crc;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic             vld_r, vld_nxt;
  logic [7:0]       data_r, data_nxt;
  logic             last_r, last_nxt;

  assign hdr      = {rec.src, rec.lon, rec.lat, rec.hum, rec.temp, rec.seq,
                     FRAME_VERSION, FRAME_MAGIC};
  assign hdr_sh   = hdr >> {idx_r, 3'b000};
  assign cur_byte = hdr_sh[7:0];
  assign at_crc   = (idx_r == CRC_IDX);
  assign adv      = rec_valid && (!vld_r || out_tready);
  assign pop      = adv && at_crc;

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

  always_comb begin
    idx_nxt  = idx_r;
    crc_nxt  = crc_r;
    data_nxt = data_r;
    last_nxt = last_r;
    vld_nxt  = vld_r && !out_tready;
    if (adv) begin
      vld_nxt  = 1'b1;
      last_nxt = at_crc;
      if (at_crc) begin
        data_nxt = crc_r;
        crc_nxt  = CRC_INIT;
        idx_nxt  = '0;
      end else begin
        data_nxt = cur_byte;
        crc_nxt  = crc8_update(crc_r, cur_byte);
        idx_nxt  = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      crc_r <= CRC_INIT;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

endmodule

>>> design/env_packet_framer.sv
// ----------------------------------------------------------------------------
// env_packet_framer
// Builds an 18-byte CRC-8 protected frame from each measurement word.
//
//  port group   dir   payload
//  in_*         in    temperature, humidity, latitude, longitude
//  out_*        out   one frame byte per word, tlast on the CRC byte
//  cfg_*        in    source id (8 bits)
//
// Each measurement becomes 18 frame bytes, one byte per cycle while out_tready
// is high, set by the byte serializer; queued frames leave back to back, no gaps.
// Input words are taken while the record queue has room, so a new word is
// accepted while the previous frame is still being sent.
// Reset (synchronous, active low) clears the sequence number, source id,
// queue and output stage. A stalled out_tready freezes the serializer.
// ----------------------------------------------------------------------------
module env_packet_framer import envpf_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // temperature_centi[15:0], humidity_centi[29:16],
                                  // latitude_e7[60:30], longitude_e7[92:61], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // frame_byte[7:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // source_id[7:0]
);

  logic push_valid, push_ready, pop_valid, pop;
  rec_t push_data, pop_data;

  assign cfg_ready = 1'b1;

  envpf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  envpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  envpf_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (pop_valid),
    .rec        (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
